// File: hdl/rpfc_pkg.sv
package rpfc_pkg;

  // Width of one usage, demand or capacity entry.
  localparam int DATA_W = 16;

  // Number of demand and default capacity fields carried by the ports.
  localparam int MAX_RES = 4;

  // Defaults for the top level parameters.
  localparam int NUM_RES_DEF = 4;
  localparam int SLOTS_DEF   = 1024;

  // Configuration port: six 32-bit registers at byte addresses 0 to 20.
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  // Width of the horizon and timed slot count registers.
  localparam int HZ_W = 11;
  localparam logic [HZ_W-1:0] HORIZON_RST = 11'd1024;

  // Register indexes, taken from paddr[4:2].
  localparam logic [CFG_IDX_W-1:0] REG_HORIZON    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMED_CNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEF_CAP_0  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEF_CAP_1  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEF_CAP_2  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEF_CAP_3  = 3'd5;

  // Item kinds.
  typedef enum logic [1:0] {
    KIND_WRITE_CAP = 2'd0,
    KIND_CHECK     = 2'd1,
    KIND_PLACE     = 2'd2,
    KIND_REMOVE    = 2'd3
  } kind_t;

endpackage

// File: hdl/resource_profile_fit_check.sv
// Resource profile fit check. After reset the block runs a clearing pass over
// the usage memory with busy high; configuration writes are taken during it.
// A timed capacity write, a zero-length job, a check whose window passes the
// horizon, and a place or remove whose window lies wholly past the horizon
// finish at once: the result strobe done is high in the cycle after the
// accepting edge and a new item may start then. Any other check, place or
// remove walks its window (clipped to the horizon for place and remove) one
// slot per cycle in the run state, reading the usage and timed capacity
// memories for all resources at once, and a single compare and saturating add
// or subtract unit per resource finishes each slot in the cycle after its read
// and writes the usage back. done is registered in the drain state that
// follows the last slot. Such a check scans the whole window. done is high
// for exactly one cycle and cannot be held off, so the receiver must take fits
// in that cycle.
module resource_profile_fit_check
  import rpfc_pkg::*;
#(
  parameter int NUM_RES = NUM_RES_DEF,
  parameter int SLOTS   = SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            kind,
  input  logic [1:0]            resource,
  input  logic [9:0]            slot,
  input  logic [DATA_W-1:0]     capacity_value,
  input  logic [9:0]            start_req,
  input  logic [10:0]           length,
  input  logic [DATA_W-1:0]     demand_0,
  input  logic [DATA_W-1:0]     demand_1,
  input  logic [DATA_W-1:0]     demand_2,
  input  logic [DATA_W-1:0]     demand_3,
  output logic                  done,
  output logic                  fits,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = (SLOT_W + 1 > 12) ? SLOT_W + 1 : 12;
  localparam logic [CNT_W-1:0]  SLOTS_C     = CNT_W'(SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT_C = SLOT_W'(SLOTS - 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_RUN,
    S_DRAIN
  } state_t;

  // Configuration registers.
  logic [HZ_W-1:0]   horizon_slots;
  logic [HZ_W-1:0]   timed_slot_count;
  logic [DATA_W-1:0] default_capacity [MAX_RES];

  // Sequencer registers.
  state_t              state;
  kind_t               op_kind;
  logic [DATA_W-1:0]   dem_q [NUM_RES];
  logic [CNT_W-1:0]    rd_tau;
  logic [CNT_W-1:0]    end_tau;
  logic [SLOT_W-1:0]   clr_addr;
  logic                fits_acc;

  // Slot pipeline stage behind the memory read.
  logic                p1_valid;
  logic [SLOT_W-1:0]   p1_tau;
  logic                p1_timed;

  // Memory read data and write port.
  logic [DATA_W-1:0]   usage_q [NUM_RES];
  logic [DATA_W-1:0]   timed_q [NUM_RES];
  logic [SLOT_W-1:0]   rd_addr;
  logic                use_wr_en;
  logic [SLOT_W-1:0]   use_wr_addr;
  logic [DATA_W-1:0]   use_wr_data [NUM_RES];
  logic                cap_wr_en;
  logic [SLOT_W-1:0]   cap_wr_addr;

  // Window arithmetic at accept.
  logic                accept;
  logic [CNT_W-1:0]    start_ext;
  logic [CNT_W-1:0]    slot_ext;
  logic [CNT_W-1:0]    win_end;
  logic [CNT_W-1:0]    eff_h;
  logic                over;
  logic [CNT_W-1:0]    end_lim;
  logic [DATA_W-1:0]   demand_in [MAX_RES];

  // Shared slot unit.
  logic [NUM_RES-1:0]  viol;
  logic                viol_any;
  logic [DATA_W-1:0]   new_u [NUM_RES];

  logic                cfg_wr;
  logic [CFG_IDX_W-1:0] cfg_idx;

  assign busy   = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);
  assign pready = 1'b1;

  assign demand_in[0] = demand_0;
  assign demand_in[1] = demand_1;
  assign demand_in[2] = demand_2;
  assign demand_in[3] = demand_3;

  // Window end, effective horizon and clipped end.
  assign start_ext = CNT_W'(start_req);
  assign slot_ext  = CNT_W'(slot);
  assign win_end   = start_ext + CNT_W'(length);
  assign eff_h     = (CNT_W'(horizon_slots) < SLOTS_C) ? CNT_W'(horizon_slots) : SLOTS_C;
  assign over      = (win_end > eff_h);
  assign end_lim   = over ? eff_h : win_end;

  // Configuration writes and reads.
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      horizon_slots    <= HORIZON_RST;
      timed_slot_count <= '0;
      for (int k = 0; k < MAX_RES; k++) begin
        default_capacity[k] <= '0;
      end
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_HORIZON:   horizon_slots       <= pwdata[HZ_W-1:0];
        REG_TIMED_CNT: timed_slot_count    <= pwdata[HZ_W-1:0];
        REG_DEF_CAP_0: default_capacity[0] <= pwdata[DATA_W-1:0];
        REG_DEF_CAP_1: default_capacity[1] <= pwdata[DATA_W-1:0];
        REG_DEF_CAP_2: default_capacity[2] <= pwdata[DATA_W-1:0];
        REG_DEF_CAP_3: default_capacity[3] <= pwdata[DATA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_HORIZON:   prdata = CFG_DATA_W'(horizon_slots);
      REG_TIMED_CNT: prdata = CFG_DATA_W'(timed_slot_count);
      REG_DEF_CAP_0: prdata = CFG_DATA_W'(default_capacity[0]);
      REG_DEF_CAP_1: prdata = CFG_DATA_W'(default_capacity[1]);
      REG_DEF_CAP_2: prdata = CFG_DATA_W'(default_capacity[2]);
      REG_DEF_CAP_3: prdata = CFG_DATA_W'(default_capacity[3]);
      default:       prdata = '0;
    endcase
  end

  // Slot unit: compare against capacity and saturate the updated usage.
  always_comb begin
    logic [DATA_W:0]   sum_u;
    logic [DATA_W-1:0] cap;
    logic [DATA_W-1:0] add_u;
    logic [DATA_W-1:0] sub_u;
    sum_u = '0;
    cap   = '0;
    add_u = '0;
    sub_u = '0;
    for (int k = 0; k < NUM_RES; k++) begin
      sum_u   = {1'b0, usage_q[k]} + {1'b0, dem_q[k]};
      cap     = p1_timed ? timed_q[k] : default_capacity[k];
      viol[k] = (sum_u > {1'b0, cap});
      add_u   = sum_u[DATA_W] ? {DATA_W{1'b1}} : sum_u[DATA_W-1:0];
      sub_u   = (usage_q[k] < dem_q[k]) ? '0 : usage_q[k] - dem_q[k];
      new_u[k] = (op_kind == KIND_PLACE) ? add_u : sub_u;
    end
  end
  assign viol_any = |viol;

  // Usage write port: clearing pass after reset, else the slot write-back.
  always_comb begin
    rd_addr = rd_tau[SLOT_W-1:0];
    if (state == S_CLEAR) begin
      use_wr_en   = 1'b1;
      use_wr_addr = clr_addr;
      for (int k = 0; k < NUM_RES; k++) begin
        use_wr_data[k] = '0;
      end
    end else begin
      use_wr_en   = p1_valid && (op_kind != KIND_CHECK);
      use_wr_addr = p1_tau;
      for (int k = 0; k < NUM_RES; k++) begin
        use_wr_data[k] = new_u[k];
      end
    end
  end

  assign cap_wr_en   = accept && (kind == KIND_WRITE_CAP) && (slot_ext < SLOTS_C);
  assign cap_wr_addr = slot_ext[SLOT_W-1:0];

  // Per-resource usage and timed capacity memories.
  for (genvar g = 0; g < NUM_RES; g++) begin : g_res
    logic [DATA_W-1:0] usage_mem [SLOTS];
    logic [DATA_W-1:0] timed_mem [SLOTS];

    always_ff @(posedge clk) begin
      if (use_wr_en) begin
        usage_mem[use_wr_addr] <= use_wr_data[g];
      end
      usage_q[g] <= usage_mem[rd_addr];
    end

    always_ff @(posedge clk) begin
      if (cap_wr_en && (resource == 2'(g))) begin
        timed_mem[cap_wr_addr] <= capacity_value;
      end
      timed_q[g] <= timed_mem[rd_addr];
    end
  end

  // Slot pipeline stage: tracks the slot whose memory data is now valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= (state == S_RUN);
    end
    p1_tau   <= rd_tau[SLOT_W-1:0];
    p1_timed <= (rd_tau < CNT_W'(timed_slot_count));
  end

  // Sequencer with the registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
      fits     <= 1'b1;
      op_kind  <= KIND_WRITE_CAP;
      fits_acc <= 1'b1;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_SLOT_C) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op_kind <= kind_t'(kind);
            for (int k = 0; k < NUM_RES; k++) begin
              dem_q[k] <= demand_in[k];
            end
            rd_tau   <= start_ext;
            end_tau  <= end_lim;
            fits_acc <= 1'b1;
            if (kind == KIND_WRITE_CAP) begin
              done <= 1'b1;
              fits <= 1'b1;
            end else if ((kind == KIND_CHECK) && (length != '0) && over) begin
              done <= 1'b1;
              fits <= 1'b0;
            end else if (start_ext < end_lim) begin
              state <= S_RUN;
            end else begin
              done <= 1'b1;
              fits <= 1'b1;
            end
          end
        end
        S_RUN: begin
          rd_tau <= rd_tau + 1'b1;
          if (p1_valid && viol_any) begin
            fits_acc <= 1'b0;
          end
          if (rd_tau + 1'b1 == end_tau) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          done  <= 1'b1;
          fits  <= (op_kind == KIND_CHECK) ? (fits_acc && !viol_any) : 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A check whose window passes the horizon answers no fit at once.
  a_over_fails: assert property (@(posedge clk) disable iff (rst)
    (accept && (kind == KIND_CHECK) && (length != '0) && over) |=> (done && !fits))
    else $error("over-horizon check did not fail at once");

  // A timed capacity write reports at once with fits high.
  a_write_done: assert property (@(posedge clk) disable iff (rst)
    (accept && (kind == KIND_WRITE_CAP)) |=> (done && fits))
    else $error("timed capacity write did not report");

  // No result leaves during the clearing pass.
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !done)
    else $error("result during clearing pass");

  // The slot stage only holds data while a window is being walked.
  a_pipe_in_run: assert property (@(posedge clk) disable iff (rst)
    p1_valid |-> ((state == S_RUN) || (state == S_DRAIN)))
    else $error("slot stage valid outside a window walk");

  // Only a check may report no fit.
  a_fits_non_check: assert property (@(posedge clk) disable iff (rst)
    (done && (op_kind != KIND_CHECK)) |-> fits)
    else $error("non-check item reported no fit");

endmodule

// File: verif/tb_top.sv
module tb_top;
  import rpfc_pkg::*;

  // One job or timed capacity write, as driven on the input ports.
  typedef struct {
    kind_t                          kind;
    logic [1:0]                     resource;
    logic [9:0]                     slot;
    logic [DATA_W-1:0]              cap_value;
    logic [9:0]                     start_slot;
    logic [10:0]                    len;
    logic [MAX_RES-1:0][DATA_W-1:0] demand;
  } job_t;

  // A directed row is either a register write or a job; want < 0 means
  // the expected fits comes from the profile model.
  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    job_t                  job;
    int                    want;
  } step_t;

  typedef enum int {CAPS_ZERO, CAPS_FULL, CAPS_MID, CAPS_MIXED} cap_mode_t;

  typedef struct {
    int unsigned hz;
    int unsigned tcnt;
    cap_mode_t   caps;
    int          items;
  } phase_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            kind = '0;
  logic [1:0]            resource = '0;
  logic [9:0]            slot = '0;
  logic [DATA_W-1:0]     capacity_value = '0;
  logic [9:0]            start_req = '0;
  logic [10:0]           length = '0;
  logic [DATA_W-1:0]     demand_0 = '0;
  logic [DATA_W-1:0]     demand_1 = '0;
  logic [DATA_W-1:0]     demand_2 = '0;
  logic [DATA_W-1:0]     demand_3 = '0;
  logic                  done;
  logic                  fits;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // Profile model state: usage per resource and slot, timed capacities,
  // and which timed entries have been written so far.
  bit [DATA_W-1:0] usage_prof [MAX_RES][SLOTS_DEF];
  bit [DATA_W-1:0] cap_timed  [MAX_RES][SLOTS_DEF];
  bit              timed_set  [MAX_RES][SLOTS_DEF];
  int unsigned     horizon_cfg = HORIZON_RST;
  int unsigned     timed_cnt_cfg = 0;
  int unsigned     def_cap_cfg [MAX_RES];

  bit    fits_due [$];
  job_t  placed_jobs [$];
  step_t directed [$];
  bit    fits_want;
  int    mismatches = 0;
  int    result_beats = 0;
  int    calm_left = 0;

  resource_profile_fit_check dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin : watchdog
    #32000000;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 50)
      $display("[%0t] MISMATCH %s", $realtime, what);
  endtask

  // Append one row to the directed table.
  function automatic void add_row(step_t t);
    directed = {directed, t};
  endfunction

  // Apply one accepted job to the profile model and return its fits.
  function automatic bit apply_job(job_t j);
    int unsigned hz, first, stop, sum, cap;
    int          s, r;
    bit          ok;
    ok = 1'b1;
    hz = (horizon_cfg < SLOTS_DEF) ? horizon_cfg : SLOTS_DEF;
    first = j.start_slot;
    stop = first + j.len;
    case (j.kind)
      KIND_WRITE_CAP: begin
        cap_timed[j.resource][j.slot] = j.cap_value;
        timed_set[j.resource][j.slot] = 1'b1;
      end
      KIND_CHECK: begin
        if (j.len != 0 && stop > hz) begin
          ok = 1'b0;
        end else begin
          for (s = first; s < stop; s++)
            for (r = 0; r < MAX_RES; r++) begin
              sum = usage_prof[r][s] + j.demand[r];
              cap = (s < timed_cnt_cfg) ? cap_timed[r][s] : def_cap_cfg[r];
              if (sum > cap) ok = 1'b0;
            end
        end
      end
      KIND_PLACE, KIND_REMOVE: begin
        if (stop > hz) stop = hz;
        for (s = first; s < stop; s++)
          for (r = 0; r < MAX_RES; r++) begin
            sum = usage_prof[r][s];
            if (j.kind == KIND_PLACE)
              sum = (sum + j.demand[r] > 16'hFFFF) ? 16'hFFFF : sum + j.demand[r];
            else
              sum = (sum < j.demand[r]) ? 0 : sum - j.demand[r];
            usage_prof[r][s] = sum[DATA_W-1:0];
          end
      end
    endcase
    return ok;
  endfunction

  function automatic logic [DATA_W-1:0] pick_capacity();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return DATA_W'($urandom);
      default: return DATA_W'($urandom_range(0, 3000));
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_demand();
    case ($urandom_range(0, 19))
      0, 1, 2: return '0;
      3, 4: return '1;
      5, 6, 7: return DATA_W'($urandom);
      default: return DATA_W'($urandom_range(0, 600));
    endcase
  endfunction

  // Every field but the kind random over its whole width; the kind is a timed capacity write.
  function automatic job_t noise_job();
    job_t j;
    j.kind = KIND_WRITE_CAP;
    j.resource = 2'($urandom);
    j.slot = 10'($urandom);
    j.cap_value = DATA_W'($urandom);
    j.start_slot = 10'($urandom);
    j.len = 11'($urandom);
    j.demand = {$urandom, $urandom};
    return j;
  endfunction

  // Random item; places are remembered so that most removes and half of
  // the checks reuse the window of a job that is really in the profile.
  function automatic job_t random_job();
    job_t j;
    int   pick, idx, lim;
    j = noise_job();
    if ($urandom_range(0, 9) < 7) j.start_slot = 10'($urandom_range(0, 127));
    pick = $urandom_range(0, 99);
    if (pick < 5) j.len = '0;
    else if (pick < 85) j.len = 11'($urandom_range(1, 32));
    else if (pick < 93) j.len = 11'($urandom_range(33, 300));
    else j.len = 11'($urandom_range(301, 2047));
    for (int r = 0; r < MAX_RES; r++) j.demand[r] = pick_demand();
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      j.kind = KIND_WRITE_CAP;
      j.cap_value = pick_capacity();
      lim = timed_cnt_cfg + 15;
      if (lim > SLOTS_DEF - 1) lim = SLOTS_DEF - 1;
      if ($urandom_range(0, 9) < 7) j.slot = 10'($urandom_range(0, lim));
    end else if (pick < 50) begin
      j.kind = KIND_CHECK;
      if (placed_jobs.size() != 0 && $urandom_range(0, 1) == 1) begin
        idx = $urandom_range(0, placed_jobs.size() - 1);
        j.start_slot = placed_jobs[idx].start_slot;
        j.len = placed_jobs[idx].len;
      end
    end else if (pick < 75) begin
      j.kind = KIND_PLACE;
      if (placed_jobs.size() < 32) placed_jobs = {placed_jobs, j};
    end else begin
      j.kind = KIND_REMOVE;
      if (placed_jobs.size() != 0 && $urandom_range(0, 3) != 0) begin
        idx = $urandom_range(0, placed_jobs.size() - 1);
        j.start_slot = placed_jobs[idx].start_slot;
        j.len = placed_jobs[idx].len;
        j.demand = placed_jobs[idx].demand;
        placed_jobs.delete(idx);
      end
    end
    return j;
  endfunction

  // Idle cycles before the next item: runs with no gaps, mostly short
  // gaps otherwise, and now and then a long one.
  function automatic int pick_gap();
    int p;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    p = $urandom_range(0, 99);
    if (p < 2) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (p < 40) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  task automatic drain_results();
    @(posedge clk);
    while (fits_due.size() != 0) @(posedge clk);
  endtask

  // Block idle: no item pending, all results back, busy low.
  task automatic settle();
    start <= 1'b0;
    drain_results();
    while (busy !== 1'b0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Drive one item and hold start until the beat is taken. A negative gap
  // waits for every due result first. start is left high for a following
  // item with no gap.
  task automatic send_job(input job_t j, input int gap, input int want);
    bit got;
    if (gap != 0) begin
      start <= 1'b0;
      if (gap < 0) drain_results();
      else repeat (gap) @(posedge clk);
    end
    kind <= j.kind;
    resource <= j.resource;
    slot <= j.slot;
    capacity_value <= j.cap_value;
    start_req <= j.start_slot;
    length <= j.len;
    demand_0 <= j.demand[0];
    demand_1 <= j.demand[1];
    demand_2 <= j.demand[2];
    demand_3 <= j.demand[3];
    start <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    got = apply_job(j);
    fits_due = {fits_due, (want < 0) ? got : (want != 0)};
  endtask

  task automatic check_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned want);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    if (prdata !== want)
      report_mismatch($sformatf("register %0d reads %h, expected %h", idx, prdata, want));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_HORIZON: horizon_cfg = val[HZ_W-1:0];
      REG_TIMED_CNT: timed_cnt_cfg = val[HZ_W-1:0];
      default: def_cap_cfg[idx - REG_DEF_CAP_0] = val[DATA_W-1:0];
    endcase
    case (idx)
      REG_HORIZON: check_reg(idx, horizon_cfg);
      REG_TIMED_CNT: check_reg(idx, timed_cnt_cfg);
      default: check_reg(idx, def_cap_cfg[idx - REG_DEF_CAP_0]);
    endcase
  endtask

  // Write every timed entry below upto that is still unwritten, so that
  // no check can read an undefined capacity.
  task automatic fill_timed(input int upto);
    job_t j;
    for (int s = 0; s < upto; s++)
      for (int r = 0; r < MAX_RES; r++)
        if (!timed_set[r][s]) begin
          j = noise_job();
          j.resource = 2'(r);
          j.slot = 10'(s);
          j.cap_value = pick_capacity();
          send_job(j, pick_gap(), -1);
        end
  endtask

  function automatic step_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    step_t t;
    t.is_cfg = 1'b1;
    t.reg_idx = idx;
    t.reg_val = val;
    t.job = noise_job();
    t.want = -1;
    return t;
  endfunction

  function automatic step_t job_row(kind_t k, logic [1:0] res, logic [9:0] slt,
                                    logic [DATA_W-1:0] capv, logic [9:0] st,
                                    logic [10:0] ln, logic [63:0] dem, int want);
    step_t t;
    t.is_cfg = 1'b0;
    t.reg_idx = REG_HORIZON;
    t.reg_val = '0;
    t.job.kind = k;
    t.job.resource = res;
    t.job.slot = slt;
    t.job.cap_value = capv;
    t.job.start_slot = st;
    t.job.len = ln;
    t.job.demand = dem;
    t.want = want;
    return t;
  endfunction

  // Compare each result beat with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      result_beats++;
      if (fits_due.size() == 0) begin
        report_mismatch($sformatf("result beat %0d with no result due", result_beats));
      end else begin
        fits_want = fits_due.pop_front();
        if (fits !== fits_want)
          report_mismatch($sformatf("result beat %0d: fits %b, predicted %b",
                                    result_beats, fits, fits_want));
      end
    end
  end

  initial begin : stimulus
    phase_t phases [6];
    int     w;
    int unsigned capv;

    phases = '{'{1024, 16, CAPS_MID, 120}, '{1, 0, CAPS_FULL, 50},
               '{300, 24, CAPS_ZERO, 110}, '{40, 1024, CAPS_MID, 120},
               '{512, 48, CAPS_MIXED, 120}, '{1000, 0, CAPS_MIXED, 110}};

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Register values after reset.
    check_reg(REG_HORIZON, horizon_cfg);
    check_reg(REG_TIMED_CNT, timed_cnt_cfg);
    for (int r = 0; r < MAX_RES; r++)
      check_reg(REG_DEF_CAP_0 + CFG_IDX_W'(r), def_cap_cfg[r]);

    // Reset configuration: zero default capacity, empty profile.
    add_row(job_row(KIND_CHECK, 0, 0, 0, 0, 1, 64'h0, 1));
    add_row(job_row(KIND_CHECK, 0, 0, 0, 0, 1, 64'h1, 0));
    add_row(job_row(KIND_CHECK, 0, 0, 0, 1023, 0, '1, 1));
    add_row(job_row(KIND_CHECK, 0, 0, 0, 1023, 1024, 64'h0, 0));
    add_row(job_row(KIND_CHECK, 0, 0, 0, 0, 2047, 64'h0, 0));
    // Full default capacity; usage saturates at both bounds.
    for (int r = 0; r < MAX_RES; r++)
      add_row(cfg_row(REG_DEF_CAP_0 + CFG_IDX_W'(r), 32'hFFFF));
    add_row(job_row(KIND_PLACE, 0, 0, 0, 0, 4, '1, 1));
    add_row(job_row(KIND_PLACE, 0, 0, 0, 0, 4, '1, 1));
    add_row(job_row(KIND_CHECK, 0, 0, 0, 0, 1, 64'h0, -1));
    add_row(job_row(KIND_CHECK, 0, 0, 0, 3, 1, 64'h0001_0000_0000_0000, -1));
    add_row(job_row(KIND_REMOVE, 0, 0, 0, 0, 4, 64'h0004_0003_0002_0001, 1));
    add_row(job_row(KIND_REMOVE, 0, 0, 0, 0, 4, '1, 1));
    add_row(job_row(KIND_CHECK, 0, 0, 0, 0, 4, '1, -1));
    // Timed capacities for slot 0 of every resource, and the top corner.
    add_row(job_row(KIND_WRITE_CAP, 0, 0, 16'h1234, 0, 0, 64'h0, 1));
    add_row(job_row(KIND_WRITE_CAP, 1, 0, 16'hFFFF, 0, 0, 64'h0, 1));
    add_row(job_row(KIND_WRITE_CAP, 2, 0, 16'hFFFF, 0, 0, 64'h0, 1));
    add_row(job_row(KIND_WRITE_CAP, 3, 0, 16'h00FF, 0, 0, 64'h0, 1));
    add_row(job_row(KIND_WRITE_CAP, 3, 1023, 16'hFFFF, 0, 0, 64'h0, 1));
    add_row(cfg_row(REG_TIMED_CNT, 1));
    add_row(job_row(KIND_CHECK, 0, 0, 0, 0, 1, 64'h1234, -1));
    add_row(job_row(KIND_CHECK, 0, 0, 0, 0, 1, 64'h1235, -1));
    // Smallest horizon: windows past it fail or are clipped.
    add_row(cfg_row(REG_HORIZON, 1));
    add_row(job_row(KIND_CHECK, 0, 0, 0, 0, 2, 64'h0, 0));
    add_row(job_row(KIND_PLACE, 0, 0, 0, 0, 1024, 64'h0005_0005_0005_0005, 1));
    add_row(job_row(KIND_PLACE, 0, 0, 0, 1023, 3, 64'h0007_0007_0007_0007, 1));
    add_row(cfg_row(REG_HORIZON, 1024));
    add_row(job_row(KIND_CHECK, 0, 0, 0, 0, 1024, 64'h00FA_0000_0000_0000, -1));
    add_row(job_row(KIND_CHECK, 0, 0, 0, 0, 1, 64'h00FB_0000_0000_0000, -1));
    add_row(job_row(KIND_REMOVE, 0, 0, 0, 0, 1, 64'h0005_0005_0005_0005, 1));
    add_row(job_row(KIND_CHECK, 0, 0, 0, 1023, 1, '1, -1));

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        settle();
        write_reg(directed[i].reg_idx, directed[i].reg_val);
      end else begin
        send_job(directed[i].job, pick_gap(), directed[i].want);
      end
    end

    // Random phases, each under its own configuration. A check only reads
    // timed entries below both the horizon and the timed count.
    foreach (phases[p]) begin
      fill_timed(int'((phases[p].tcnt < phases[p].hz) ? phases[p].tcnt : phases[p].hz));
      settle();
      write_reg(REG_HORIZON, phases[p].hz);
      write_reg(REG_TIMED_CNT, phases[p].tcnt);
      for (int r = 0; r < MAX_RES; r++) begin
        case (phases[p].caps)
          CAPS_ZERO: capv = 0;
          CAPS_FULL: capv = 16'hFFFF;
          CAPS_MID: capv = $urandom_range(1000, 20000);
          default: begin
            case ($urandom_range(0, 2))
              0: capv = 0;
              1: capv = 16'hFFFF;
              default: capv = $urandom_range(1000, 20000);
            endcase
          end
        endcase
        write_reg(REG_DEF_CAP_0 + CFG_IDX_W'(r), capv);
      end
      for (int n = 0; n < phases[p].items; n++)
        send_job(random_job(), ($urandom_range(0, 99) < 3) ? -1 : pick_gap(), -1);
    end

    // Wind down: every prediction must be answered, then nothing more.
    start <= 1'b0;
    for (w = 0; fits_due.size() != 0 && w < 300000; w++) @(posedge clk);
    repeat (1100) @(posedge clk);
    if (fits_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", fits_due.size()));
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
